// ===== sv/rtli_pkg.sv =====
// Shared constants, codes and types of the regular-table linear interpolator.
package rtli_pkg;

    // Table geometry and fixed-point format
    localparam int TABLE_DEPTH = 1024;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // Field widths fixed by the interface
    localparam int VAL_W   = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int CFG_W   = 32;

    // Position product and its integer part
    localparam int PROD_W = 2 * VAL_W;
    localparam int IDX_W  = PROD_W - 2 * FRAC_BITS;
    localparam int CMP_W  = (IDX_W > VAL_W) ? IDX_W : VAL_W;

    // Weight times sample difference
    localparam int DELTA_W = VAL_W + 1;
    localparam int WPROD_W = FRAC_BITS + 1 + DELTA_W;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Out-of-range modes
    localparam logic MODE_EXTEND = 1'b0;
    localparam logic MODE_ZERO   = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ORIGIN_X        = 2'd0,
        REG_INVERSE_SPACING = 2'd1,
        REG_SAMPLE_COUNT    = 2'd2,
        REG_OUT_OF_RANGE    = 2'd3
    } reg_index_t;

endpackage

// ===== sv/rtli_if.sv =====
// Handshake channel interfaces for items and results.
interface rtli_item_if
    import rtli_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0]   sample_value;
    logic signed [VAL_W-1:0]   query_x;

    modport source (output valid, kind, entry_index, sample_value, query_x, input ready);
    modport sink   (input valid, kind, entry_index, sample_value, query_x, output ready);
endinterface

interface rtli_result_if
    import rtli_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VAL_W-1:0]   interp_value;
    logic                      outside_domain;

    modport source (output valid, interp_value, outside_domain, input ready);
    modport sink   (input valid, interp_value, outside_domain, output ready);
endinterface

// ===== sv/regular_table_linear_interp_top.sv =====
// Top level: pipelined sample table with linear interpolation between entries.
//
//  channel  | dir | transaction carries
//  ---------+-----+------------------------------------------------------
//  item     | in  | kind, entry_index, sample_value, query_x
//  result   | out | interp_value, outside_domain (one per query only)
//  cfg_*    | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// One item per cycle while no stall holds the pipeline; a query passes six
// register stages (subtract, position multiply, compare and table read,
// difference, weight multiply, add into the output register).
// Loads write the table in the table-read stage, so they stay in order with queries.
// Reset sets config registers to defaults and clears all stage valid bits;
// table contents are undefined until loaded. Each stage advances when its
// successor has room, so a stalled result only holds items that cannot move forward.
module regular_table_linear_interp_top
    import rtli_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    rtli_item_if.sink           item,
    rtli_result_if.source       result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    // Configuration registers
    logic signed [VAL_W-1:0] origin_x_reg;
    logic [VAL_W-1:0]        inverse_spacing_reg;
    logic [COUNT_W-1:0]      sample_count_reg;
    logic                    out_of_range_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg          <= '0;
            inverse_spacing_reg   <= VAL_W'(1) << FRAC_BITS;
            sample_count_reg      <= '0;
            out_of_range_mode_reg <= MODE_EXTEND;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_ORIGIN_X:        origin_x_reg          <= cfg_wdata[VAL_W-1:0];
                REG_INVERSE_SPACING: inverse_spacing_reg   <= cfg_wdata[VAL_W-1:0];
                REG_SAMPLE_COUNT:    sample_count_reg      <= cfg_wdata[COUNT_W-1:0];
                REG_OUT_OF_RANGE:    out_of_range_mode_reg <= cfg_wdata[0];
                default:             ;
            endcase
        end
    end

    // Stage valids and advance chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic adv1, adv2, adv3, adv4, adv5, adv_out;

    assign adv_out = !out_valid_reg || result.ready;
    assign adv5    = !s5_valid_reg || adv_out;
    assign adv4    = !s4_valid_reg || adv5;
    assign adv3    = !s3_valid_reg || adv4;
    assign adv2    = !s2_valid_reg || adv3;
    assign adv1    = !s1_valid_reg || adv2;

    assign item.ready = adv1;

    // Stage 1: offset from origin, exact in 33 bits
    logic                     s1_kind_reg;
    logic [INDEX_W-1:0]       s1_index_reg;
    logic [VAL_W-1:0]         s1_sample_reg;
    logic signed [VAL_W:0]    s1_diff_reg;
    logic signed [VAL_W:0]    s1_diff_next;

    assign s1_diff_next = {item.query_x[VAL_W-1], item.query_x}
                        - {origin_x_reg[VAL_W-1], origin_x_reg};

    // Stage 2: position = offset times inverse spacing
    logic                     s2_kind_reg;
    logic [INDEX_W-1:0]       s2_index_reg;
    logic [VAL_W-1:0]         s2_sample_reg;
    logic                     s2_neg_reg;
    logic [IDX_W-1:0]         s2_idx_reg;
    logic [FRAC_BITS-1:0]     s2_frac_reg;
    logic [PROD_W-1:0]        s2_prod_next;

    assign s2_prod_next = PROD_W'(s1_diff_reg[VAL_W-1:0]) * PROD_W'(inverse_spacing_reg);

    // Stage 3: segment check and table read / load write
    logic [CMP_W-1:0]   count_sat;
    logic [CMP_W-1:0]   segs;
    logic [CMP_W-1:0]   idx_ext;
    logic [CMP_W-1:0]   last_addr;
    logic [CMP_W-1:0]   idx_plus1;
    logic               past_end;
    logic               s2_outside;
    logic               s2_zero;
    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_b;
    logic               load_in_range;
    logic               ram_we;
    logic               ram_re;
    logic [VAL_W-1:0]   s3_s0;
    logic [VAL_W-1:0]   s3_s1;

    always_comb
    begin
        count_sat = (CMP_W'(sample_count_reg) > CMP_W'(TABLE_DEPTH))
                  ? CMP_W'(TABLE_DEPTH) : CMP_W'(sample_count_reg);
        segs      = (count_sat == '0) ? '0 : count_sat - CMP_W'(1);
        last_addr = count_sat - CMP_W'(1);
        idx_ext   = CMP_W'(s2_idx_reg);
        idx_plus1 = idx_ext + CMP_W'(1);
        past_end  = idx_ext >= segs;
        s2_outside = s2_neg_reg || past_end;
        s2_zero    = s2_outside
                   && ((out_of_range_mode_reg == MODE_ZERO) || (count_sat < CMP_W'(2)));
        if (s2_neg_reg)
        begin
            addr_a = '0;
        end
        else if (past_end)
        begin
            addr_a = last_addr[ADDR_W-1:0];
        end
        else
        begin
            addr_a = idx_ext[ADDR_W-1:0];
        end
        addr_b        = idx_plus1[ADDR_W-1:0];
        load_in_range = CMP_W'(s2_index_reg) < CMP_W'(TABLE_DEPTH);
        ram_we = adv3 && s2_valid_reg && (s2_kind_reg == KIND_LOAD) && load_in_range;
        ram_re = adv3 && s2_valid_reg && (s2_kind_reg == KIND_QUERY);
    end

    rtli_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (s2_index_reg),
        .wdata   (s2_sample_reg),
        .re      (ram_re),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (s3_s0),
        .rdata_b (s3_s1)
    );

    logic                 s3_outside_reg;
    logic                 s3_zero_reg;
    logic [FRAC_BITS-1:0] s3_frac_reg;

    // Stage 4: sample difference, forced to zero outside the domain
    logic                      s4_outside_reg;
    logic                      s4_zero_reg;
    logic [FRAC_BITS-1:0]      s4_frac_reg;
    logic signed [VAL_W-1:0]   s4_s0_reg;
    logic signed [DELTA_W-1:0] s4_delta_reg;
    logic signed [DELTA_W-1:0] s4_delta_next;

    assign s4_delta_next = s3_outside_reg ? '0
                         : ({s3_s1[VAL_W-1], s3_s1} - {s3_s0[VAL_W-1], s3_s0});

    // Stage 5: weight times difference
    logic                      s5_outside_reg;
    logic                      s5_zero_reg;
    logic signed [VAL_W-1:0]   s5_s0_reg;
    logic signed [WPROD_W-1:0] s5_wprod_reg;
    logic signed [WPROD_W-1:0] s5_wprod_next;

    assign s5_wprod_next = $signed({1'b0, s4_frac_reg}) * s4_delta_reg;

    // Output stage: floor shift and add
    logic signed [VAL_W-1:0]   out_value_reg;
    logic                      out_outside_reg;
    logic signed [WPROD_W-1:0] sum_full;
    logic signed [VAL_W-1:0]   out_value_next;

    assign sum_full       = WPROD_W'(s5_s0_reg) + (s5_wprod_reg >>> FRAC_BITS);
    assign out_value_next = s5_zero_reg ? '0 : sum_full[VAL_W-1:0];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= item.valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            // loads leave the pipeline at the table stage
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg && (s2_kind_reg == KIND_QUERY);
            end
            if (adv4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (adv5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_kind_reg   <= item.kind;
            s1_index_reg  <= item.entry_index;
            s1_sample_reg <= item.sample_value;
            s1_diff_reg   <= s1_diff_next;
        end
        if (adv2)
        begin
            s2_kind_reg   <= s1_kind_reg;
            s2_index_reg  <= s1_index_reg;
            s2_sample_reg <= s1_sample_reg;
            s2_neg_reg    <= s1_diff_reg[VAL_W];
            s2_idx_reg    <= s2_prod_next[PROD_W-1:2*FRAC_BITS];
            s2_frac_reg   <= s2_prod_next[2*FRAC_BITS-1:FRAC_BITS];
        end
        if (adv3)
        begin
            s3_outside_reg <= s2_outside;
            s3_zero_reg    <= s2_zero;
            s3_frac_reg    <= s2_frac_reg;
        end
        if (adv4)
        begin
            s4_outside_reg <= s3_outside_reg;
            s4_zero_reg    <= s3_zero_reg;
            s4_frac_reg    <= s3_frac_reg;
            s4_s0_reg      <= s3_s0;
            s4_delta_reg   <= s4_delta_next;
        end
        if (adv5)
        begin
            s5_outside_reg <= s4_outside_reg;
            s5_zero_reg    <= s4_zero_reg;
            s5_s0_reg      <= s4_s0_reg;
            s5_wprod_reg   <= s5_wprod_next;
        end
        if (adv_out)
        begin
            out_value_reg   <= out_value_next;
            out_outside_reg <= s5_outside_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.interp_value   = out_value_reg;
    assign result.outside_domain = out_outside_reg;

endmodule

// ===== sv/rtli_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
module rtli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, output held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== test/regular_table_linear_interp_top_tb.sv =====
// Self-checking testbench for the regular-table linear interpolator: loads, queries, configs.
module regular_table_linear_interp_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtli_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_PHASE   = 7;
    localparam int HOLD_CYCLES  = 400;

    typedef longint unsigned u64_t;

    typedef enum {LOC_BEFORE, LOC_INSIDE, LOC_PAST} seg_loc_t;

    typedef struct {
        logic                    kind;
        logic [INDEX_W-1:0]      entry_index;
        logic signed [VAL_W-1:0] sample_value;
        logic signed [VAL_W-1:0] query_x;
    } lookup_item_t;

    typedef struct {
        logic signed [VAL_W-1:0] interp_value;
        logic                    outside_domain;
    } lookup_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    rtli_item_if   item_ch();
    rtli_result_if result_ch();

    regular_table_linear_interp_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow of the configuration, reset values
    logic signed [VAL_W-1:0] org      = '0;
    logic [CFG_W-1:0]        inv      = 32'h0001_0000;
    logic [COUNT_W-1:0]      cnt      = '0;
    logic                    oor_mode = MODE_EXTEND;

    // Predicted table contents and the generator's record of loaded entries
    logic signed [VAL_W-1:0] sample_mem [TABLE_DEPTH];
    bit                      loaded     [TABLE_DEPTH];

    lookup_item_t   item_backlog[$];
    lookup_result_t expected_results[$];
    lookup_item_t   on_bus;

    int items_pushed  = 0;
    int items_taken   = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int phase_num     = 0;
    int rx_hold_left  = 0;
    bit rx_hold_done  = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Samples in use, saturated at the table depth
    function automatic int live_count();
        return (cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);
    endfunction

    function automatic u64_t segments();
        int n;
        n = live_count();
        return (n > 0) ? u64_t'(n - 1) : 0;
    endfunction

    // Segment index and weight of a query under the current setting
    function automatic seg_loc_t locate(input logic signed [VAL_W-1:0] x,
                                        output u64_t seg, output logic [FRAC_BITS-1:0] w);
        longint dl;
        u64_t   prod;
        seg = 0;
        w   = '0;
        dl  = longint'(x) - longint'(org);
        if (dl < 0)
            return LOC_BEFORE;
        prod = u64_t'(dl) * u64_t'(inv);
        seg  = prod >> (2 * FRAC_BITS);
        w    = prod[2*FRAC_BITS-1:FRAC_BITS];
        return (seg >= segments()) ? LOC_PAST : LOC_INSIDE;
    endfunction

    // Expected answer to a query
    function automatic lookup_result_t interpolate(input logic signed [VAL_W-1:0] x);
        lookup_result_t       r;
        seg_loc_t             loc;
        u64_t                 seg;
        logic [FRAC_BITS-1:0] w;
        longint               s0;
        longint               s1;
        longint               wprod;
        loc = locate(x, seg, w);
        r.interp_value   = '0;
        r.outside_domain = 1'b1;
        if (loc == LOC_INSIDE)
        begin
            s0 = longint'(sample_mem[seg]);
            s1 = longint'(sample_mem[seg + 1]);
            wprod = longint'(w) * (s1 - s0);
            r.interp_value   = VAL_W'(s0 + (wprod >>> FRAC_BITS));
            r.outside_domain = 1'b0;
        end
        else if (oor_mode == MODE_EXTEND && live_count() >= 2)
        begin
            r.interp_value = (loc == LOC_BEFORE) ? sample_mem[0] : sample_mem[live_count() - 1];
        end
        return r;
    endfunction

    // Apply one accepted transaction to the predicted state
    function automatic void predict_item(input lookup_item_t it);
        if (it.kind == KIND_LOAD)
            sample_mem[it.entry_index] = it.sample_value;
        else
            expected_results = {expected_results, interpolate(it.query_x)};
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_sample();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2:
            begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_x(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[VAL_W-1:0];
    endfunction

    // Query somewhere around the domain, a little past both ends
    function automatic logic signed [VAL_W-1:0] near_x();
        u64_t   span;
        u64_t   range;
        u64_t   r;
        longint d;
        if (inv == 0)
            return $urandom;
        span  = ((segments() << 32) + inv - 1) / inv;
        range = span + span / 4 + 8;
        r     = {$urandom, $urandom};
        r     = r % range;
        d     = longint'(r) - longint'(span / 8) - 4;
        return clamp_x(longint'(org) + d);
    endfunction

    // Query on or next to a segment boundary
    function automatic logic signed [VAL_W-1:0] boundary_x();
        int   k;
        int   jitter;
        u64_t d;
        if (inv == 0)
            return $urandom;
        k      = $urandom_range(0, int'(segments()));
        jitter = int'($urandom_range(0, 2)) - 1;
        d      = ((u64_t'(k) << 32) + inv - 1) / inv;
        return clamp_x(longint'(org) + longint'(d) + jitter);
    endfunction

    task automatic add_load(input int idx, input logic signed [VAL_W-1:0] val);
        lookup_item_t it;
        it.kind         = KIND_LOAD;
        it.entry_index  = idx[INDEX_W-1:0];
        it.sample_value = val;
        it.query_x      = $urandom;
        loaded[idx]     = 1'b1;
        item_backlog    = {item_backlog, it};
        items_pushed++;
    endtask

    task automatic ensure_loaded(input int idx);
        if (!loaded[idx])
            add_load(idx, rand_sample());
    endtask

    // Queue a query, loading first any entry it would read that was never written
    task automatic add_query(input logic signed [VAL_W-1:0] x);
        lookup_item_t         it;
        seg_loc_t             loc;
        u64_t                 seg;
        logic [FRAC_BITS-1:0] w;
        loc = locate(x, seg, w);
        if (loc == LOC_INSIDE)
        begin
            ensure_loaded(int'(seg));
            ensure_loaded(int'(seg) + 1);
        end
        else if (oor_mode == MODE_EXTEND && live_count() >= 2)
        begin
            ensure_loaded((loc == LOC_BEFORE) ? 0 : live_count() - 1);
        end
        it.kind         = KIND_QUERY;
        it.entry_index  = INDEX_W'($urandom);
        it.sample_value = $urandom;
        it.query_x      = x;
        item_backlog    = {item_backlog, it};
        items_pushed++;
    endtask

    task automatic gen_random(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 25)
                add_load($urandom_range(0, TABLE_DEPTH - 1), rand_sample());
            else if (r < 35)
                add_query($urandom);
            else if (r < 50)
                add_query(boundary_x());
            else
                add_query(near_x());
        end
    endtask

    // Wait until every transaction is in and every result is out, then let loads retire
    task automatic drain();
        while (items_taken != items_pushed || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write per cycle; call right after a rising edge
    task automatic set_reg(input reg_index_t r, input logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        case (r)
            REG_ORIGIN_X:        org      = v;
            REG_INVERSE_SPACING: inv      = v;
            REG_SAMPLE_COUNT:    cnt      = v[COUNT_W-1:0];
            REG_OUT_OF_RANGE:    oor_mode = v[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] o, input logic [CFG_W-1:0] s,
                                input int c, input logic m);
        logic [CFG_W-1:0] dc;
        logic [CFG_W-1:0] dm;
        // upper bits carry junk; only the register width counts
        dc = $urandom;
        dc[COUNT_W-1:0] = c[COUNT_W-1:0];
        dm = $urandom;
        dm[0] = m;
        set_reg(REG_ORIGIN_X, o);
        set_reg(REG_INVERSE_SPACING, s);
        set_reg(REG_SAMPLE_COUNT, dc);
        set_reg(REG_OUT_OF_RANGE, dm);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int num, input logic [CFG_W-1:0] o,
                             input logic [CFG_W-1:0] s, input int c, input logic m,
                             input int n, input int sp, input int rp);
        write_config(o, s, c, m);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        phase_num     = num;
        gen_random(n);
        drain();
    endtask

    // Item driver: presents the backlog, predicts on each accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid        <= 1'b0;
            item_ch.kind         <= KIND_LOAD;
            item_ch.entry_index  <= '0;
            item_ch.sample_value <= '0;
            item_ch.query_x      <= '0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predict_item(on_bus);
                items_taken++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (item_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = item_backlog.pop_front();
                    item_ch.valid        <= 1'b1;
                    item_ch.kind         <= on_bus.kind;
                    item_ch.entry_index  <= on_bus.entry_index;
                    item_ch.sample_value <= on_bus.sample_value;
                    item_ch.query_x      <= on_bus.query_x;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result ready: random back-pressure plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (!rx_hold_done && phase_num == HOLD_PHASE)
        begin
            rx_hold_done = 1'b1;
            rx_hold_left = HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor: compare against the oldest expectation
    always @(posedge clk)
    begin : result_check
        lookup_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: interp_value %h outside_domain %b",
                         $time, result_ch.interp_value, result_ch.outside_domain);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_ch.interp_value !== want.interp_value)
                begin
                    $display("%0t: interp_value mismatch: expected %h, actual %h",
                             $time, want.interp_value, result_ch.interp_value);
                    fail_count++;
                end
                if (result_ch.outside_domain !== want.outside_domain)
                begin
                    $display("%0t: outside_domain mismatch: expected %b, actual %b",
                             $time, want.outside_domain, result_ch.outside_domain);
                    fail_count++;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 85;

        // Reset setting: no samples, every query answers zero
        add_query(32'h0000_0000);
        add_load(0, 32'h7FFF_FFFF);
        add_load(1, 32'h8000_0000);
        add_load(2, 32'h0000_0000);
        add_load(TABLE_DEPTH - 1, 32'h8000_0000);
        add_query(32'h7FFF_FFFF);
        drain();

        // Three samples at unit spacing, extend mode: both ends, full-scale swing
        write_config(32'h0000_0000, 32'h0001_0000, 3, MODE_EXTEND);
        add_query(32'hFFFF_FFFF);
        add_query(32'h0000_0000);
        add_query(32'h0000_8000);
        add_query(32'h0001_FFFF);
        add_query(32'h0002_0000);
        add_query(32'h7FFF_FFFF);
        add_query(32'h8000_0000);
        drain();

        // Zero spacing, count above depth, zero mode
        write_config(32'h0000_0000, 32'h0000_0000, 2047, MODE_ZERO);
        add_query(32'h0000_0005);
        add_query(32'hFFFF_FFFB);
        add_query(32'h7FFF_FFFF);
        drain();

        // A single sample
        write_config(32'h0000_0000, 32'h0000_0000, 1, MODE_ZERO);
        add_query(32'h0000_0000);
        add_query(32'h8000_0000);
        drain();

        // Random phases over several settings
        run_phase(1, 32'hFFFD_0000, 32'h0000_8000, 16, MODE_EXTEND, 300, 18, 85);
        run_phase(2, 32'h8000_0000, 32'hFFFF_FFFF, 1024, MODE_ZERO, 200, 18, 85);
        run_phase(3, 32'h7FFF_FFFF, 32'h0000_0001, 2047, MODE_EXTEND, 100, 85, 18);
        run_phase(4, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                  $urandom_range(32'h800, 32'h40_0000), $urandom_range(2, 64),
                  MODE_ZERO, 300, 85, 18);
        run_phase(5, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000, 32'h0000_0000, 5,
                  MODE_EXTEND, 80, 0, 0);
        run_phase(6, $urandom, $urandom, 1, MODE_ZERO, 80, 0, 0);
        run_phase(HOLD_PHASE, $urandom, $urandom_range(32'h1000, 32'h10_0000),
                  $urandom_range(2, 200), 1'($urandom_range(0, 1)), 340, 0, 0);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
